FILE: sv/sha256_pkg.sv
// Package with SHA-256 constants, types and round functions shared by the hasher modules.
package sha256_pkg;

	localparam logic [31:0] Iv [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenOffset = 6'd56;

	// Byte-level fill commands from the controller.
	typedef enum logic [1:0] {
		FILL_NONE = 2'd0,
		FILL_DATA = 2'd1,
		FILL_PAD  = 2'd2,
		FILL_ZERO = 2'd3
	} fill_op_t;

	// Commands from controller to datapath.
	typedef struct packed {
		fill_op_t   fill;
		logic [5:0] fill_addr;
		logic       fill_len;    // write length byte for fill_addr >= 56
		logic       count_block; // bit count += 512
		logic       load_w;      // load schedule word from buffer
		logic       start;       // copy chaining value into working vars
		logic       round;       // execute one round
		logic [5:0] round_idx;
		logic       finish;      // add working vars into chaining value
		logic       shift_out;   // rotate chaining value one word
		logic       reinit;      // back to initial value, clear counters
	} dp_cmd_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

FILE: sv/sha256_if.sv
// Valid/ready stream interfaces for message items and digest words.
interface sha256_in_if (input logic clk);
	logic       valid;
	logic       ready;
	logic [7:0] message_byte;
	logic       byte_present;
	logic       end_of_message;
	modport source (output valid, message_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, message_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if (input logic clk);
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        digest_last;
	modport source (output valid, digest_word, digest_last, input ready);
	modport sink (input valid, digest_word, digest_last, output ready);
endinterface

FILE: sv/sha256_message_hasher.sv
// Top level of the streaming SHA-256 hasher.
// At most one message byte is taken per item; a byte that fills the 64-byte block stalls input for
// 16 schedule loads, a setup step and 64 rounds (one round per cycle in the shared round unit),
// plus a fold into the chaining value. The item marked end_of_message starts padding, written
// one byte per cycle, and one or two further compressions; the eight digest words then leave
// most significant first, and the next message starts from the initial value.
module sha256_message_hasher (
	input logic clk,
	input logic arst_n,
	sha256_in_if.sink   in_ch,
	sha256_out_if.source out_ch
);

	sha256_pkg::dp_cmd_t cmd;
	logic [31:0]         cv_word;

	sha256_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_present (in_ch.byte_present),
		.in_end     (in_ch.end_of_message),
		.in_ready   (in_ch.ready),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_last   (out_ch.digest_last),
		.cmd        (cmd)
	);

	sha256_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (in_ch.message_byte),
		.cv_word   (cv_word)
	);

	assign out_ch.digest_word = cv_word;

	// Input is never taken while a digest is pending.
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input ready during digest output");

	// The last word returns the hasher to accepting input.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.digest_last |=> in_ch.ready)
		else $error("hasher not ready after last digest word");

	// A digest word that is not taken stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.digest_word))
		else $error("digest word changed while stalled");

endmodule

FILE: sv/sha256_datapath.sv
// Datapath: block buffer, message schedule, round registers, chaining value, bit counter.
module sha256_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  sha256_pkg::dp_cmd_t cmd,
	input  logic [7:0]          data_byte,
	output logic [31:0]         cv_word
);

	logic [31:0] buf_q [16];
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] cv_q [8];
	logic [63:0] bits_q;
	logic [31:0] w_new;
	logic [31:0] w_cur;
	logic [31:0] x1;
	logic [31:0] x2;
	logic [7:0]  wr_byte;

	// Byte written into the buffer for the current fill command.
	always_comb begin
		unique case (cmd.fill)
			sha256_pkg::FILL_DATA: wr_byte = data_byte;
			sha256_pkg::FILL_PAD:  wr_byte = sha256_pkg::PadByte;
			sha256_pkg::FILL_ZERO: wr_byte = cmd.fill_len ?
				8'(bits_q >> (8 * (63 - int'(cmd.fill_addr)))) : 8'd0;
			default:               wr_byte = 8'd0;
		endcase
	end

	// The block is held as sixteen big-endian words; each byte goes into its lane.
	always_ff @(posedge clk) begin
		if (cmd.fill != sha256_pkg::FILL_NONE) begin
			buf_q[cmd.fill_addr[5:2]][{~cmd.fill_addr[1:0], 3'd0} +: 8] <= wr_byte;
		end
	end

	// Schedule: first 16 words from the buffer, then extended in a 16-deep window.
	assign w_new = sha256_pkg::sig1(w_q[14]) + w_q[9] + sha256_pkg::sig0(w_q[1]) + w_q[0];
	assign w_cur = (cmd.round_idx < 6'd16) ? w_q[0] : w_new;

	always_ff @(posedge clk) begin
		if (cmd.load_w) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= buf_q[cmd.round_idx[3:0]];
		end else if (cmd.round && cmd.round_idx >= 6'd16) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_q[0];
		end
	end

	// One compression round per cycle.
	assign x1 = v_q[7] + sha256_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ sha256_pkg::RoundK[cmd.round_idx] + w_cur;
	assign x2 = sha256_pkg::bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2])
		^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			v_q <= cv_q;
		end else if (cmd.round) begin
			v_q[0] <= x1 + x2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + x1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	// Chaining value and bit counter; the tail bytes are counted when the pad byte is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q   <= sha256_pkg::Iv;
			bits_q <= '0;
		end else if (cmd.reinit) begin
			cv_q   <= sha256_pkg::Iv;
			bits_q <= '0;
		end else begin
			if (cmd.finish) begin
				for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + v_q[i];
			end else if (cmd.shift_out) begin
				for (int i = 0; i < 7; i++) cv_q[i] <= cv_q[i+1];
				cv_q[7] <= cv_q[0];
			end
			if (cmd.count_block) bits_q <= bits_q + 64'd512;
			else if (cmd.fill == sha256_pkg::FILL_PAD) bits_q <= bits_q + {55'd0, cmd.fill_addr, 3'd0};
		end
	end

	assign cv_word = cv_q[0];

endmodule

FILE: sv/sha256_ctrl.sv
// Controller state machine sequencing byte loads, padding, rounds and digest output.
module sha256_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_present,
	input  logic                in_end,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_last,
	output sha256_pkg::dp_cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LOAD  = 7'b0000010,
		S_START = 7'b0000100,
		S_ROUND = 7'b0001000,
		S_FIN   = 7'b0010000,
		S_PAD   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [5:0]  addr_q;   // bytes in block
	logic [5:0]  idx_q;
	logic        final_q;  // compressing the block that holds the length
	logic        ending_q; // padding in progress
	logic        mark_q;   // the 0x80 byte is still to be written
	logic [2:0]  word_q;
	logic        accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == S_OUT);
	assign out_last  = (word_q == 3'd7);

	// Command decode.
	always_comb begin
		cmd = '0;
		cmd.round_idx = idx_q;
		cmd.fill_addr = addr_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && in_present) cmd.fill = sha256_pkg::FILL_DATA;
			end
			S_LOAD:  cmd.load_w = 1'b1;
			S_START: cmd.start = 1'b1;
			S_ROUND: cmd.round = 1'b1;
			S_FIN: begin
				cmd.finish = 1'b1;
				cmd.count_block = !ending_q;
			end
			S_PAD: begin
				cmd.fill = mark_q ? sha256_pkg::FILL_PAD : sha256_pkg::FILL_ZERO;
				cmd.fill_len = final_q && (addr_q >= sha256_pkg::LenOffset);
			end
			S_OUT: begin
				cmd.shift_out = out_ready;
				cmd.reinit = out_ready && out_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			addr_q   <= '0;
			idx_q    <= '0;
			final_q  <= 1'b0;
			ending_q <= 1'b0;
			mark_q   <= 1'b0;
			word_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_present && addr_q == 6'd63) begin
							state_q <= S_LOAD;
							idx_q   <= '0;
							addr_q  <= '0;
							ending_q <= 1'b0;
							final_q <= in_end;
						end else if (in_present) begin
							addr_q <= addr_q + 6'd1;
							if (in_end) begin
								state_q <= S_PAD;
								ending_q <= 1'b1;
								mark_q <= 1'b1;
								final_q <= (addr_q + 6'd1) < sha256_pkg::LenOffset;
							end
						end else if (in_end) begin
							state_q <= S_PAD;
							ending_q <= 1'b1;
							mark_q <= 1'b1;
							final_q <= addr_q < sha256_pkg::LenOffset;
						end
					end
				end
				S_LOAD: begin
					idx_q <= idx_q + 6'd1;
					if (idx_q == 6'd15) begin
						idx_q   <= '0;
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_ROUND;
				S_ROUND: begin
					idx_q <= idx_q + 6'd1;
					if (idx_q == 6'd63) state_q <= S_FIN;
				end
				S_FIN: begin
					if (ending_q && final_q) begin
						state_q <= S_OUT;
						word_q  <= '0;
					end else if (ending_q || final_q) begin
						// A full block ended the message and the pad byte opens the next block, or the padding ran past the length field.
						state_q  <= S_PAD;
						mark_q   <= !ending_q;
						final_q  <= 1'b1;
						ending_q <= 1'b1;
						addr_q   <= '0;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_PAD: begin
					addr_q <= addr_q + 6'd1;
					mark_q <= 1'b0;
					if (addr_q == 6'd63) begin
						state_q <= S_LOAD;
						idx_q   <= '0;
						addr_q  <= '0;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						word_q <= word_q + 3'd1;
						if (out_last) begin
							state_q  <= S_IDLE;
							addr_q   <= '0;
							final_q  <= 1'b0;
							ending_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: tb/sha256_tb_if.sv
// Testbench package with the input item type.
package sha256_tb_util;
	typedef struct packed {
		logic [7:0] message_byte;
		logic       byte_present;
		logic       end_of_message;
	} msg_item_t;
endpackage

FILE: tb/tb.sv
// Self-checking testbench for the streaming SHA-256 message hasher.
module tb;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   errors;

	sha256_in_if  in_ch (clk);
	sha256_out_if out_ch (clk);

	sha256_message_hasher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// Hasher state mirrored by the predictor.
	logic [31:0] chain_h [8];
	logic [7:0]  blk_bytes [64];
	int          blk_fill;
	logic [63:0] msg_bits;

	sha256_tb_util::msg_item_t pending_items [$];
	logic [32:0]               expected_words [$];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One 64-round compression of the buffered block into the chaining value.
	task automatic compress_blk();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] x1;
		logic [31:0] x2;
		logic [31:0] s0;
		logic [31:0] s1;
		for (int t = 0; t < 16; t++)
			w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		for (int t = 0; t < 8; t++)
			v[t] = chain_h[t];
		for (int t = 0; t < 64; t++) begin
			x1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[t] + w[t];
			x2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int k = 7; k > 0; k--)
				v[k] = v[k-1];
			v[4] = v[4] + x1;
			v[0] = x1 + x2;
		end
		for (int t = 0; t < 8; t++)
			chain_h[t] = chain_h[t] + v[t];
	endtask

	task automatic reset_hash();
		for (int t = 0; t < 8; t++)
			chain_h[t] = sha256_pkg::Iv[t];
		blk_fill = 0;
		msg_bits = '0;
	endtask

	// Absorbs one accepted item and queues any digest words it produces.
	task automatic predict_digest(input sha256_tb_util::msg_item_t it);
		logic [63:0] len;
		int i;
		if (it.byte_present) begin
			blk_bytes[blk_fill] = it.message_byte;
			blk_fill++;
			if (blk_fill == 64) begin
				compress_blk();
				msg_bits += 64'd512;
				blk_fill = 0;
			end
		end
		if (it.end_of_message) begin
			i = blk_fill;
			blk_bytes[i++] = sha256_pkg::PadByte;
			while (i < 64)
				blk_bytes[i++] = 8'h00;
			if (blk_fill >= 56) begin
				compress_blk();
				for (int k = 0; k < 64; k++)
					blk_bytes[k] = 8'h00;
			end
			len = msg_bits + 64'(blk_fill) * 64'd8;
			for (int k = 0; k < 8; k++)
				blk_bytes[63-k] = len[8*k +: 8];
			compress_blk();
			for (int k = 0; k < 8; k++)
				expected_words.push_back({chain_h[k], k == 7});
			reset_hash();
		end
	endtask

	task automatic add_item(input logic [7:0] b, input logic bp, input logic eom);
		sha256_tb_util::msg_item_t it;
		it.message_byte = b;
		it.byte_present = bp;
		it.end_of_message = eom;
		pending_items.push_back(it);
	endtask

	// Random short message, ended either with a byte or with an empty end item.
	task automatic add_message(input int len);
		for (int k = 0; k < len; k++)
			add_item(8'($urandom), 1'b1, 1'b0);
		if ($urandom_range(0, 1))
			add_item(8'($urandom), 1'b0, 1'b1);
		else
			add_item(8'($urandom), 1'b1, 1'b1);
	endtask

	// Driver: presents queued items, idles at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.message_byte <= '0;
			in_ch.byte_present <= 1'b0;
			in_ch.end_of_message <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_digest(sha256_tb_util::msg_item_t'{in_ch.message_byte,
					in_ch.byte_present, in_ch.end_of_message});
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_ch.valid <= 1'b1;
					in_ch.message_byte <= pending_items[0].message_byte;
					in_ch.byte_present <= pending_items[0].byte_present;
					in_ch.end_of_message <= pending_items[0].end_of_message;
					void'(pending_items.pop_front());
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted digest word with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t unexpected digest word: actual %h last %b", $time,
						out_ch.digest_word, out_ch.digest_last);
					errors++;
				end else begin
					if (out_ch.digest_word !== expected_words[0][32:1]
						|| out_ch.digest_last !== expected_words[0][0]) begin
						$display("%0t digest mismatch: expected %h last %b, actual %h last %b",
							$time, expected_words[0][32:1], expected_words[0][0],
							out_ch.digest_word, out_ch.digest_last);
						errors++;
					end
					void'(expected_words.pop_front());
				end
			end
			out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#3000000;
		$display("[sha256_message_hasher] ERROR");
		$finish;
	end

	initial begin
		errors = 0;
		send_idle_pct = 21;
		recv_idle_pct = 71;
		reset_hash();
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle item, empty message, short message.
		add_item(8'h00, 1'b0, 1'b0);
		add_item(8'hff, 1'b0, 1'b1);
		add_item(8'h61, 1'b1, 1'b0);
		add_item(8'h62, 1'b1, 1'b0);
		add_item(8'h63, 1'b1, 1'b1);
		// A tail past the length field, so padding takes two blocks.
		for (int k = 0; k < 59; k++)
			add_item(8'($urandom), 1'b1, 1'b0);
		add_item(8'hff, 1'b1, 1'b1);

		// Random messages over the three idling phases.
		for (int ph = 0; ph < 3; ph++) begin
			for (int m = 0; m < 3; m++) begin
				add_message($urandom_range(0, 10));
				if ($urandom_range(0, 3) == 0)
					add_item(8'($urandom), 1'b0, 1'b0);
			end
			wait (pending_items.size() == 0 && !in_ch.valid);
			wait (expected_words.size() == 0);
			repeat (300) @(posedge clk);
			send_idle_pct = (ph == 0) ? 71 : 0;
			recv_idle_pct = (ph == 0) ? 21 : 0;
		end

		if (errors == 0 && expected_words.size() == 0) begin
			$display("[sha256_message_hasher] OK");
		end else begin
			$display("[sha256_message_hasher] ERROR");
		end
		$finish;
	end
endmodule

FILE: sim.f
sv/sha256_pkg.sv
sv/sha256_if.sv
sv/sha256_datapath.sv
sv/sha256_ctrl.sv
sv/sha256_message_hasher.sv
tb/sha256_tb_if.sv
tb/tb.sv
